FILE: rtl/rgba_overlay_blend_yuy2_core_macros.svh
// Assertion macros shared by the overlay blend RTL.
`ifndef RGBA_OVERLAY_BLEND_YUY2_CORE_MACROS_SVH
`define RGBA_OVERLAY_BLEND_YUY2_CORE_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define RGBOVL_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rgbovl assertion failed");

// Next-cycle implication, checked out of reset.
`define RGBOVL_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rgbovl assertion failed");

`endif

FILE: rtl/rgbovl_pkg.sv
// Types, constants and arithmetic helpers for the overlay blend pipeline.
package rgbovl_pkg;

    localparam int unsigned PixW  = 32;
    localparam int unsigned ChanW = 8;

    // BT.601 luma weights and offsets
    localparam logic [15:0] LUMA_KR    = 16'd66;
    localparam logic [15:0] LUMA_KG    = 16'd129;
    localparam logic [15:0] LUMA_KB    = 16'd25;
    localparam logic [15:0] LUMA_ROUND = 16'd128;
    localparam logic [7:0]  LUMA_OFS   = 8'd16;

    // BT.601 chroma weights (V then U)
    localparam logic signed [16:0] V_KR = 17'sd112;
    localparam logic signed [16:0] V_KG = -17'sd94;
    localparam logic signed [16:0] V_KB = -17'sd18;
    localparam logic signed [16:0] U_KR = -17'sd38;
    localparam logic signed [16:0] U_KG = -17'sd74;
    localparam logic signed [16:0] U_KB = 17'sd112;
    localparam logic signed [16:0] CHROMA_ROUND = 17'sd128;
    localparam logic signed [16:0] TRUNC_BIAS   = 17'sd255;
    localparam logic [7:0]         CHROMA_OFS   = 8'd128;

    localparam logic [7:0] ALPHA_MAX = 8'd255;

    typedef struct packed {
        logic [PixW-1:0] prev_px;
        logic [PixW-1:0] left_px;
        logic [PixW-1:0] right_px;
        logic [PixW-1:0] next_px;
        logic [PixW-1:0] src_word;
    } tap_t;

    typedef struct packed {
        logic [ChanW-1:0] src_y0;
        logic [ChanW-1:0] src_u;
        logic [ChanW-1:0] src_y1;
        logic [ChanW-1:0] src_v;
        logic [ChanW-1:0] ovl_y0;
        logic [ChanW-1:0] ovl_y1;
        logic [ChanW-1:0] alpha_left;
        logic [ChanW-1:0] alpha_right;
        logic [ChanW-1:0] ovl_u;
        logic [ChanW-1:0] ovl_v;
        logic [ChanW-1:0] alpha_c;
        logic             chroma_on;
    } conv_t;

    typedef struct packed {
        logic [ChanW-1:0] luma_left;
        logic [ChanW-1:0] chroma_blue;
        logic [ChanW-1:0] luma_right;
        logic [ChanW-1:0] chroma_red;
    } out_item_t;

    function automatic logic [7:0] luma_of(input logic [PixW-1:0] px);
        logic [15:0] sum;
        sum = LUMA_KR * {8'd0, px[7:0]} + LUMA_KG * {8'd0, px[15:8]}
            + LUMA_KB * {8'd0, px[23:16]} + LUMA_ROUND;
        return sum[15:8] + LUMA_OFS;
    endfunction

    // Signed /256 truncating toward zero, then recenter on 128.
    function automatic logic [7:0] chroma_of(input logic [PixW-1:0] px,
                                             input logic signed [16:0] kr,
                                             input logic signed [16:0] kg,
                                             input logic signed [16:0] kb);
        logic signed [16:0] s;
        logic signed [16:0] q;
        s = kr * $signed({9'd0, px[7:0]}) + kg * $signed({9'd0, px[15:8]})
          + kb * $signed({9'd0, px[23:16]}) + CHROMA_ROUND;
        q = s[16] ? ((s + TRUNC_BIAS) >>> 8) : (s >>> 8);
        return q[7:0] + CHROMA_OFS;
    endfunction

    function automatic logic [7:0] filt121(input logic [7:0] p,
                                           input logic [7:0] c,
                                           input logic [7:0] n);
        logic [9:0] t;
        t = {2'd0, p} + {1'b0, c, 1'b0} + {2'd0, n};
        return t[9:2];
    endfunction

    // (ov*a + src*(255-a)) / 255; the /255 is exact for sums below 2^16
    function automatic logic [7:0] blend(input logic [7:0] ov,
                                         input logic [7:0] src,
                                         input logic [7:0] a);
        logic [15:0] x;
        logic [16:0] t;
        x = {8'd0, ov} * {8'd0, a} + {8'd0, src} * {8'd0, ALPHA_MAX - a};
        t = {1'b0, x} + {9'd0, x[15:8]} + 17'd1;
        return t[15:8];
    endfunction

endpackage

FILE: rtl/rgbovl_in_if.sv
// Input channel: overlay pixel pair, video macropixel and row flags.
interface rgbovl_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] overlay_left;
    logic [31:0] overlay_right;
    logic [31:0] source_word;
    logic        row_start;
    logic        row_end;

    modport source (output valid, output overlay_left, output overlay_right,
                    output source_word, output row_start, output row_end,
                    input ready);
    modport sink (input valid, input overlay_left, input overlay_right,
                  input source_word, input row_start, input row_end,
                  output ready);
endinterface

FILE: rtl/rgbovl_out_if.sv
// Output channel: blended YUY2 macropixel.
interface rgbovl_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] luma_left;
    logic [7:0] chroma_blue;
    logic [7:0] luma_right;
    logic [7:0] chroma_red;

    modport source (output valid, output luma_left, output chroma_blue,
                    output luma_right, output chroma_red, input ready);
    modport sink (input valid, input luma_left, input chroma_blue,
                  input luma_right, input chroma_red, output ready);
endinterface

FILE: rtl/rgbovl_convert.sv
// Color conversion stage: overlay luma, filtered chroma and filtered alpha.
module rgbovl_convert
    import rgbovl_pkg::*;
(
    input  tap_t  taps,
    output conv_t conv
);

    logic [7:0] v_prev, v_cur, v_next;
    logic [7:0] u_prev, u_cur, u_next;
    logic [7:0] a_prev, a_cur, a_next;

    always_comb
    begin
        v_prev = chroma_of(taps.prev_px, V_KR, V_KG, V_KB);
        v_cur  = chroma_of(taps.left_px, V_KR, V_KG, V_KB);
        v_next = chroma_of(taps.next_px, V_KR, V_KG, V_KB);
        u_prev = chroma_of(taps.prev_px, U_KR, U_KG, U_KB);
        u_cur  = chroma_of(taps.left_px, U_KR, U_KG, U_KB);
        u_next = chroma_of(taps.next_px, U_KR, U_KG, U_KB);
        a_prev = taps.prev_px[31:24];
        a_cur  = taps.left_px[31:24];
        a_next = taps.next_px[31:24];

        conv.src_y0      = taps.src_word[7:0];
        conv.src_u       = taps.src_word[15:8];
        conv.src_y1      = taps.src_word[23:16];
        conv.src_v       = taps.src_word[31:24];
        conv.ovl_y0      = luma_of(taps.left_px);
        conv.ovl_y1      = luma_of(taps.right_px);
        conv.alpha_left  = taps.left_px[31:24];
        conv.alpha_right = taps.right_px[31:24];
        conv.ovl_u       = filt121(u_prev, u_cur, u_next);
        conv.ovl_v       = filt121(v_prev, v_cur, v_next);
        conv.alpha_c     = filt121(a_prev, a_cur, a_next);
        // chroma follows the source only when all three taps are transparent
        conv.chroma_on   = (a_prev != 8'd0) || (a_cur != 8'd0) || (a_next != 8'd0);
    end

endmodule

FILE: rtl/rgbovl_mix.sv
// Blend stage: mix overlay luma and chroma into the video samples.
module rgbovl_mix
    import rgbovl_pkg::*;
(
    input  conv_t     conv,
    output out_item_t result
);

    always_comb
    begin
        result.luma_left   = (conv.alpha_left == 8'd0) ? conv.src_y0
                           : blend(conv.ovl_y0, conv.src_y0, conv.alpha_left);
        result.luma_right  = (conv.alpha_right == 8'd0) ? conv.src_y1
                           : blend(conv.ovl_y1, conv.src_y1, conv.alpha_right);
        result.chroma_blue = conv.chroma_on ? blend(conv.ovl_u, conv.src_u, conv.alpha_c)
                           : conv.src_u;
        result.chroma_red  = conv.chroma_on ? blend(conv.ovl_v, conv.src_v, conv.alpha_c)
                           : conv.src_v;
    end

endmodule

FILE: rtl/rgba_overlay_blend_yuy2_core.sv
// Top level: RGBA overlay blended onto a YUY2 stream, three register stages.
//
//   channel   direction  transaction
//   pix_in    sink       two RGBA overlay pixels, one YUY2 macropixel, row flags
//   pix_out   source     one blended YUY2 macropixel
//
// One macropixel per clock sustained while pix_out is ready; pix_in reaches pix_out
// through the input, conversion and result registers, in that order.
// The whole pipeline advances together whenever the result register is empty or taken.
// rst_n clears the stage valid bits and the held previous right overlay pixel.
// The previous right pixel updates on every accepted pix_in transaction.
`include "rgba_overlay_blend_yuy2_core_macros.svh"

module rgba_overlay_blend_yuy2_core
    import rgbovl_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    rgbovl_in_if.sink   pix_in,
    rgbovl_out_if.source pix_out
);

    logic            advance;
    logic            in_fire;

    logic            s0_valid_reg;
    tap_t            taps_reg;
    tap_t            taps_next;
    logic [PixW-1:0] prev_px_reg;

    logic            s1_valid_reg;
    conv_t           conv_reg;
    conv_t           conv_next;

    logic            out_valid_reg;
    out_item_t       result_reg;
    out_item_t       result_next;

    assign advance      = !out_valid_reg || pix_out.ready;
    assign pix_in.ready = advance;
    assign in_fire      = pix_in.valid && advance;

    // pick the outer filter taps at the row edges
    always_comb
    begin
        taps_next.prev_px  = pix_in.row_start ? pix_in.overlay_left : prev_px_reg;
        taps_next.left_px  = pix_in.overlay_left;
        taps_next.right_px = pix_in.overlay_right;
        taps_next.next_px  = pix_in.row_end ? pix_in.overlay_left : pix_in.overlay_right;
        taps_next.src_word = pix_in.source_word;
    end

    rgbovl_convert u_convert (
        .taps (taps_reg),
        .conv (conv_next)
    );

    rgbovl_mix u_mix (
        .conv   (conv_reg),
        .result (result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg  <= 1'b0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            prev_px_reg   <= '0;
        end
        else if (advance)
        begin
            s0_valid_reg  <= pix_in.valid;
            s1_valid_reg  <= s0_valid_reg;
            out_valid_reg <= s1_valid_reg;
            if (pix_in.valid)
            begin
                prev_px_reg <= pix_in.overlay_right;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            taps_reg   <= taps_next;
            conv_reg   <= conv_next;
            result_reg <= result_next;
        end
    end

    assign pix_out.valid       = out_valid_reg;
    assign pix_out.luma_left   = result_reg.luma_left;
    assign pix_out.chroma_blue = result_reg.chroma_blue;
    assign pix_out.luma_right  = result_reg.luma_right;
    assign pix_out.chroma_red  = result_reg.chroma_red;

    `RGBOVL_ASSERT_NEXT(a_fire_fills_s0, in_fire, s0_valid_reg)
    `RGBOVL_ASSERT_NEXT(a_stall_holds_s1, s1_valid_reg && !advance, s1_valid_reg)
    `RGBOVL_ASSERT_NEXT(a_clear_left_passes, s1_valid_reg && advance && conv_reg.alpha_left == 8'd0, pix_out.luma_left == $past(conv_reg.src_y0))
    `RGBOVL_ASSERT_NEXT(a_clear_chroma_passes, s1_valid_reg && advance && !conv_reg.chroma_on, pix_out.chroma_blue == $past(conv_reg.src_u))

endmodule

FILE: test/tb_top.sv
// Testbench for the RGBA-over-YUY2 blend core: directed and random macropixels checked against a local predictor.
module tb_top;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 20;
    localparam int REPORT_LIMIT = 10;
    localparam int HOLD_OFF_CYCLES = 150;

    localparam int LUMA_KR    = 66;
    localparam int LUMA_KG    = 129;
    localparam int LUMA_KB    = 25;
    localparam int LUMA_OFS   = 16;
    localparam int ROUND_HALF = 128;
    localparam int CHROMA_MID = 128;
    localparam int ALPHA_FULL = 255;
    localparam int CR_KR = 112;
    localparam int CR_KG = -94;
    localparam int CR_KB = -18;
    localparam int CB_KR = -38;
    localparam int CB_KG = -74;
    localparam int CB_KB = 112;

    logic clk = 1'b0;
    logic rst_n;

    rgbovl_in_if  pix_in_ch ();
    rgbovl_out_if pix_out_ch ();

    rgba_overlay_blend_yuy2_core u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .pix_in  (pix_in_ch),
        .pix_out (pix_out_ch)
    );

    logic [31:0]             held_right_pixel;
    rgbovl_pkg::out_item_t   expected_pixels[$];
    int                      error_count = 0;
    int                      cycle_count = 0;
    bit                      src_gaps_on;
    bit                      sink_stalls_on;
    int                      hold_request;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic logic [7:0] overlay_luma(input logic [31:0] px);
        int r;
        int g;
        int b;
        int sum;
        r = px[7:0];
        g = px[15:8];
        b = px[23:16];
        sum = LUMA_KR * r + LUMA_KG * g + LUMA_KB * b + ROUND_HALF;
        return 8'((sum >> 8) + LUMA_OFS);
    endfunction

    // Signed division truncates toward zero, as the chroma path requires.
    function automatic logic [7:0] overlay_chroma(input logic [31:0] px, input int kr,
                                                  input int kg, input int kb);
        int r;
        int g;
        int b;
        int sum;
        r = px[7:0];
        g = px[15:8];
        b = px[23:16];
        sum = kr * r + kg * g + kb * b + ROUND_HALF;
        return 8'(sum / 256 + CHROMA_MID);
    endfunction

    function automatic logic [7:0] tap_filter(input logic [7:0] p, input logic [7:0] c,
                                              input logic [7:0] n);
        int sum;
        sum = int'(p) + 2 * int'(c) + int'(n);
        return 8'(sum >> 2);
    endfunction

    function automatic logic [7:0] mix_alpha(input logic [7:0] ov, input logic [7:0] src,
                                             input logic [7:0] a);
        int sum;
        sum = int'(ov) * int'(a) + int'(src) * (ALPHA_FULL - int'(a));
        return 8'(sum / ALPHA_FULL);
    endfunction

    function automatic rgbovl_pkg::out_item_t blend_macropixel(
        input logic [31:0] left, input logic [31:0] right, input logic [31:0] src,
        input logic rs, input logic re, input logic [31:0] prev_right);
        rgbovl_pkg::out_item_t res;
        logic [31:0] tap_prev;
        logic [31:0] tap_next;
        logic [7:0]  alpha_c;
        res.luma_left  = (left[31:24] == 8'd0) ? src[7:0]
                       : mix_alpha(overlay_luma(left), src[7:0], left[31:24]);
        res.luma_right = (right[31:24] == 8'd0) ? src[23:16]
                       : mix_alpha(overlay_luma(right), src[23:16], right[31:24]);
        res.chroma_blue = src[15:8];
        res.chroma_red  = src[31:24];
        tap_prev = rs ? left : prev_right;
        tap_next = re ? left : right;
        if (tap_prev[31:24] != 8'd0 || left[31:24] != 8'd0 || tap_next[31:24] != 8'd0)
        begin
            alpha_c = tap_filter(tap_prev[31:24], left[31:24], tap_next[31:24]);
            res.chroma_blue = mix_alpha(tap_filter(overlay_chroma(tap_prev, CB_KR, CB_KG, CB_KB),
                                                   overlay_chroma(left, CB_KR, CB_KG, CB_KB),
                                                   overlay_chroma(tap_next, CB_KR, CB_KG, CB_KB)),
                                        src[15:8], alpha_c);
            res.chroma_red  = mix_alpha(tap_filter(overlay_chroma(tap_prev, CR_KR, CR_KG, CR_KB),
                                                   overlay_chroma(left, CR_KR, CR_KG, CR_KB),
                                                   overlay_chroma(tap_next, CR_KR, CR_KG, CR_KB)),
                                        src[31:24], alpha_c);
        end
        return res;
    endfunction

    // Alpha leans toward the transparent and opaque ends.
    function automatic logic [31:0] random_overlay_pixel();
        logic [31:0] px;
        px = $urandom();
        case ($urandom_range(0, 3))
            0: px[31:24] = 8'h00;
            1: px[31:24] = 8'hFF;
            default: ;
        endcase
        return px;
    endfunction

    task automatic send_macropixel(input logic [31:0] left, input logic [31:0] right,
                                   input logic [31:0] src, input logic rs, input logic re);
        if (src_gaps_on && $urandom_range(0, 4) == 0)
        begin
            pix_in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        pix_in_ch.valid         <= 1'b1;
        pix_in_ch.overlay_left  <= left;
        pix_in_ch.overlay_right <= right;
        pix_in_ch.source_word   <= src;
        pix_in_ch.row_start     <= rs;
        pix_in_ch.row_end       <= re;
        @(posedge clk);
        while (!pix_in_ch.ready) @(posedge clk);
        expected_pixels.push_back(blend_macropixel(left, right, src, rs, re, held_right_pixel));
        held_right_pixel = right;
    endtask

    task automatic check_field(input string field, input logic [7:0] want,
                               input logic [7:0] got);
        if (got !== want)
        begin
            error_count++;
            if (error_count <= REPORT_LIMIT)
                $display("mismatch on %s: expected %02h, got %02h", field, want, got);
        end
    endtask

    always @(posedge clk)
    begin : result_checker
        rgbovl_pkg::out_item_t want;
        if (rst_n && pix_out_ch.valid && pix_out_ch.ready)
        begin
            if (expected_pixels.size() == 0)
            begin
                error_count++;
                if (error_count <= REPORT_LIMIT)
                    $display("unexpected output transaction: %02h %02h %02h %02h",
                             pix_out_ch.luma_left, pix_out_ch.chroma_blue,
                             pix_out_ch.luma_right, pix_out_ch.chroma_red);
            end
            else
            begin
                want = expected_pixels.pop_front();
                check_field("luma_left", want.luma_left, pix_out_ch.luma_left);
                check_field("chroma_blue", want.chroma_blue, pix_out_ch.chroma_blue);
                check_field("luma_right", want.luma_right, pix_out_ch.luma_right);
                check_field("chroma_red", want.chroma_red, pix_out_ch.chroma_red);
            end
        end
    end

    initial
    begin : ready_driver
        int stall_left;
        int hold_left;
        stall_left = 0;
        hold_left  = 0;
        pix_out_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request > 0)
            begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                pix_out_ch.ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                pix_out_ch.ready <= 1'b0;
            end
            else if (sink_stalls_on && $urandom_range(0, 4) == 0)
            begin
                stall_left = $urandom_range(0, 5);
                pix_out_ch.ready <= 1'b0;
            end
            else
                pix_out_ch.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("rgba_overlay_blend_yuy2_core test failed");
            $finish;
        end
    end

    task automatic test_directed_edges();
        // No row start right after reset: previous tap is the cleared pixel.
        send_macropixel(32'hFFFF_FFFF, 32'hFF00_0000, 32'h8010_80EB, 1'b0, 1'b0);
        send_macropixel(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b1, 1'b1);
        send_macropixel(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1);
        send_macropixel(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 1'b0);
        // Transparent left pixel, then transparent right pixel.
        send_macropixel(32'h00FF_8040, 32'hFF20_4080, 32'h5A3C_7E11, 1'b1, 1'b0);
        send_macropixel(32'hFF20_4080, 32'h00FF_8040, 32'h11C3_9E7A, 1'b0, 1'b0);
        // All three chroma taps transparent.
        send_macropixel(32'h0012_3456, 32'h00AB_CDEF, 32'hC3A5_5A3C, 1'b0, 1'b0);
        // Row start and end together fold both outer taps onto the transparent left.
        send_macropixel(32'h00FF_FFFF, 32'hFF00_FF00, 32'h7F80_017E, 1'b1, 1'b1);
        // Pure primaries drive the chroma sums negative and positive.
        send_macropixel(32'hFF00_00FF, 32'hFF00_FF00, 32'h8080_8080, 1'b1, 1'b0);
        send_macropixel(32'hFFFF_0000, 32'hFF00_00FF, 32'h8080_8080, 1'b0, 1'b1);
        send_macropixel(32'h80FF_0000, 32'h8000_FF00, 32'h00FF_00FF, 1'b0, 1'b1);
        send_macropixel(32'h0100_00FF, 32'hFE00_FF00, 32'hFF00_FF00, 1'b1, 1'b0);
        send_macropixel(32'hFE12_3456, 32'h01FE_DCBA, 32'h0000_0000, 1'b0, 1'b0);
        send_macropixel(32'h7F80_8080, 32'h7F7F_7F7F, 32'hFFFF_FFFF, 1'b0, 1'b1);
        // Row end alone: next tap is the left pixel.
        send_macropixel(32'h40C0_2010, 32'hFF00_0000, 32'h2468_ACE0, 1'b0, 1'b1);
        send_macropixel(32'hFF00_0000, 32'h40C0_2010, 32'h1357_9BDF, 1'b1, 1'b0);
    endtask

    // Well-formed rows of random length with random content.
    task automatic test_row_sequences(input int pair_target, input bit allow_idle);
        int sent;
        int row_len;
        sent = 0;
        while (sent < pair_target)
        begin
            row_len = $urandom_range(1, 12);
            src_gaps_on    = allow_idle && ($urandom_range(0, 3) != 0);
            sink_stalls_on = allow_idle && ($urandom_range(0, 3) != 0);
            for (int i = 0; i < row_len; i++)
                send_macropixel(random_overlay_pixel(), random_overlay_pixel(), $urandom(),
                                i == 0, i == row_len - 1);
            sent += row_len;
        end
    endtask

    // Hold the output off while items keep coming, so the pipeline backs up.
    task automatic test_output_hold_off();
        hold_request = HOLD_OFF_CYCLES;
        test_row_sequences(40, 1'b0);
    endtask

    task automatic test_row_flag_noise(input int pair_count);
        src_gaps_on    = 1'b1;
        sink_stalls_on = 1'b1;
        repeat (pair_count)
            send_macropixel(random_overlay_pixel(), random_overlay_pixel(), $urandom(),
                            1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    endtask

    initial
    begin
        rst_n                   <= 1'b0;
        pix_in_ch.valid         <= 1'b0;
        pix_in_ch.overlay_left  <= '0;
        pix_in_ch.overlay_right <= '0;
        pix_in_ch.source_word   <= '0;
        pix_in_ch.row_start     <= 1'b0;
        pix_in_ch.row_end       <= 1'b0;
        held_right_pixel = '0;
        src_gaps_on      = 1'b0;
        sink_stalls_on   = 1'b0;
        hold_request     = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_edges();
        test_row_sequences(520, 1'b1);
        test_output_hold_off();
        test_row_flag_noise(120);
        src_gaps_on    = 1'b0;
        sink_stalls_on = 1'b0;
        test_row_sequences(200, 1'b0);

        pix_in_ch.valid <= 1'b0;
        while (expected_pixels.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("rgba_overlay_blend_yuy2_core test passed");
        else
            $display("rgba_overlay_blend_yuy2_core test failed");
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/rgbovl_pkg.sv
rtl/rgbovl_in_if.sv
rtl/rgbovl_out_if.sv
rtl/rgbovl_convert.sv
rtl/rgbovl_mix.sv
rtl/rgba_overlay_blend_yuy2_core.sv
test/tb_top.sv
